/* rtl/scs_pkg.sv */
// ============================================================================
// scs_pkg: shared definitions for the sorted coordinate set
// Sizes, action and status codes, and the command and status bundles that
// pass between the controller and the datapath.
// ============================================================================
package scs_pkg;

    // Table size and the widths that follow from it.
    localparam int CAPACITY  = 64;
    localparam int IDX_W     = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Fixed field widths of the beats.
    localparam int COORD_W   = 8;
    localparam int KEY_W     = 2 * COORD_W;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 3;
    localparam int OUT_IDX_W = 7;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [IDX_W-1:0]    index_t;
    typedef logic [CNT_W-1:0]    count_t;

    localparam action_t ACT_CLEAR  = 2'd0;
    localparam action_t ACT_INSERT = 2'd1;
    localparam action_t ACT_LOOKUP = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_CLEARED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_LOOKUP    = 3'd4
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take a new input beat
        logic probe;     // read the table at the search midpoint
        logic compare;   // compare the key with the probed entry
        logic decide;    // search finished: settle the result code
        logic shift_rd;  // read the entry below the shift pointer
        logic shift_wr;  // write it one place up
        logic final_wr;  // write the new key and bump the count
        logic out_load;  // load the result register
    } scs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic search_open;
        logic insert_ok;
        logic shift_more;
    } scs_stat_t;

endpackage

/* rtl/scs_if.sv */
// ============================================================================
// scs_if: handshake channels of the sorted coordinate set
// One interface for the request beats and one for the result beats.
// ============================================================================
interface scs_in_if;
    import scs_pkg::*;

    logic    valid;
    logic    ready;
    action_t action;
    logic [COORD_W-1:0] key_x;
    logic [COORD_W-1:0] key_y;

    modport source (output valid, output action, output key_x, output key_y,
                    input ready);
    modport sink   (input valid, input action, input key_x, input key_y,
                    output ready);
endinterface

interface scs_out_if;
    import scs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 found;
    logic [OUT_IDX_W-1:0] position;
    logic [OUT_IDX_W-1:0] entry_count;

    modport source (output valid, output status, output found, output position,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input found, input position,
                    input entry_count, output ready);
endinterface

/* rtl/scs_ram.sv */
// ============================================================================
// scs_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module scs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]             rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

/* rtl/scs_ctrl.sv */
// ============================================================================
// scs_ctrl: sequencer of the sorted coordinate set
// Steps the binary search, the upward shift of an insert and the hand-off
// of the result to the output register.
// ============================================================================
module scs_ctrl
    import scs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output scs_cmd_t  cmd,
    input  scs_stat_t stat
);
    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_PROBE    = 6'b000010,
        S_COMPARE  = 6'b000100,
        S_SHIFT_RD = 6'b001000,
        S_SHIFT_WR = 6'b010000,
        S_FINISH   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (stat.search_open)
                begin
                    cmd.probe  = 1'b1;
                    state_next = S_COMPARE;
                end
                else
                begin
                    cmd.decide = 1'b1;
                    state_next = stat.insert_ok ? S_SHIFT_RD : S_FINISH;
                end
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = S_PROBE;
            end
            S_SHIFT_RD:
            begin
                if (stat.shift_more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
                else
                begin
                    cmd.final_wr = 1'b1;
                    state_next   = S_FINISH;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // A compare always uses the read issued by the probe just before it.
    a_compare_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_COMPARE |-> $past(state_reg) == S_PROBE)
        else $error("compare step without a preceding probe");

    // A finished item never leaves a result behind unloaded.
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_ready) |=> (state_reg == S_IDLE && out_valid_reg))
        else $error("result not handed over on leaving finish");
endmodule

/* rtl/scs_datapath.sv */
// ============================================================================
// scs_datapath: key table and search registers
// Holds the sorted key memory, the search bounds, the count and the result.
// ============================================================================
module scs_datapath
    import scs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  scs_cmd_t             cmd,
    output scs_stat_t            stat,
    input  action_t              action,
    input  logic [COORD_W-1:0]   key_x,
    input  logic [COORD_W-1:0]   key_y,
    output logic [STATUS_W-1:0]  status,
    output logic                 found,
    output logic [OUT_IDX_W-1:0] position,
    output logic [OUT_IDX_W-1:0] entry_count
);
    action_t action_reg;
    key_t    key_reg;
    count_t  lo_reg, hi_reg, ptr_reg, count_reg;
    logic    hit_reg;
    status_t status_reg;

    status_t              res_status_reg;
    logic                 res_found_reg;
    logic [OUT_IDX_W-1:0] res_position_reg;
    logic [OUT_IDX_W-1:0] res_count_reg;

    logic [CNT_W:0] mid_sum;
    count_t         mid;
    index_t         rd_addr, wr_addr;
    key_t           wr_data, rd_data;
    logic           rd_en, wr_en;
    logic           is_full;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = count_t'(mid_sum >> 1);
    assign is_full = (count_reg >= count_t'(CAPACITY));

    assign stat.search_open = (lo_reg < hi_reg) && !hit_reg;
    assign stat.insert_ok   = (action_reg == ACT_INSERT) && !hit_reg && !is_full;
    assign stat.shift_more  = (ptr_reg > lo_reg);

    // Memory ports: search probes and shift reads share the read port.
    assign rd_en   = cmd.probe || cmd.shift_rd;
    assign rd_addr = cmd.probe ? index_t'(mid) : index_t'(ptr_reg - 1'b1);
    assign wr_en   = cmd.shift_wr || cmd.final_wr;
    assign wr_addr = cmd.final_wr ? index_t'(lo_reg) : index_t'(ptr_reg);
    assign wr_data = cmd.final_wr ? key_reg : rd_data;

    scs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.load && action == ACT_CLEAR)
        begin
            count_reg <= '0;
        end
        else if (cmd.final_wr)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            key_reg    <= {key_y, key_x};
            lo_reg     <= '0;
            hi_reg     <= (action == ACT_CLEAR) ? count_t'(0) : count_reg;
            hit_reg    <= 1'b0;
        end
        if (cmd.compare)
        begin
            if (key_reg < rd_data)
            begin
                hi_reg <= mid;
            end
            else if (key_reg > rd_data)
            begin
                lo_reg <= mid + 1'b1;
            end
            else
            begin
                hit_reg <= 1'b1;
                lo_reg  <= mid;
            end
        end
        if (cmd.decide)
        begin
            ptr_reg <= count_reg;
            priority if (action_reg == ACT_CLEAR)
            begin
                status_reg <= ST_CLEARED;
            end
            else if (action_reg == ACT_INSERT)
            begin
                status_reg <= hit_reg ? ST_DUPLICATE : (is_full ? ST_FULL : ST_INSERTED);
            end
            else
            begin
                status_reg <= ST_LOOKUP;
            end
        end
        if (cmd.shift_wr)
        begin
            ptr_reg <= ptr_reg - 1'b1;
        end
        if (cmd.out_load)
        begin
            res_status_reg   <= status_reg;
            res_found_reg    <= hit_reg;
            res_position_reg <= OUT_IDX_W'(lo_reg);
            res_count_reg    <= OUT_IDX_W'(count_reg);
        end
    end

    assign status      = res_status_reg;
    assign found       = res_found_reg;
    assign position    = res_position_reg;
    assign entry_count = res_count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= count_t'(CAPACITY))
        else $error("key count beyond capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.final_wr |=> count_reg == count_t'($past(count_reg) + 1'b1))
        else $error("insert did not grow the count by one");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe |-> (mid < count_reg && lo_reg < hi_reg))
        else $error("search probe outside the held entries");
endmodule

/* rtl/sorted_coordinate_set_core.sv */
// ============================================================================
// sorted_coordinate_set_core: sorted set of (x,y) byte coordinates
// Top level joining the sequencer and the datapath to the two channels.
// ============================================================================
// The block keeps up to CAPACITY unique keys (64 as built) in a RAM, sorted
// by y and then x, and answers one request beat with exactly one result
// beat. It works on one request at a time. A clear goes straight from the
// decide step to the finish state; a lookup, a rejected insert or a
// duplicate first runs its binary search steps (at most 7 with 64 entries),
// since each step issues one read of the key RAM and then compares its
// registered data; a successful insert then shifts the m entries above
// the insertion point up one place, moving one entry per read
// and write pair through the single read port. The result sits in an
// output register, so a new request is taken while an earlier result still
// waits for its consumer; a further result waits only if that register is
// still full. The key RAM needs no clearing after reset: only entries below
// the count are ever read.
module sorted_coordinate_set_core
    import scs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    scs_in_if.sink      in_ch,
    scs_out_if.source   out_ch
);
    scs_cmd_t  cmd;
    scs_stat_t stat;

    // The sequencer owns both handshakes; the datapath owns the payload.
    scs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Key table, search bounds, count and the result register.
    scs_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (in_ch.action),
        .key_x       (in_ch.key_x),
        .key_y       (in_ch.key_y),
        .status      (out_ch.status),
        .found       (out_ch.found),
        .position    (out_ch.position),
        .entry_count (out_ch.entry_count)
    );
endmodule

/* tb/sorted_coordinate_set_core_test.sv */
// ============================================================================
// sorted_coordinate_set_core_test: self-checking bench for the coordinate set
// Drives request beats from a queue and predicts every result beat with a
// behavioural copy of the sorted table. It compares each result field by
// field. Both channels stall at random in the first two of three phases.
// ============================================================================
module sorted_coordinate_set_core_test;
    import scs_pkg::*;

    // The spare action code has no name in the package. The block treats it
    // as a lookup.
    localparam action_t ACT_SPARE     = 2'd3;
    localparam int      RANDOM_ITEMS  = 800;
    localparam int      STALL_LIMIT   = 20000;
    localparam int      DRAIN_CYCLES  = 300;

    typedef struct packed {
        action_t              action;
        logic [COORD_W-1:0]   key_x;
        logic [COORD_W-1:0]   key_y;
    } request_t;

    typedef struct packed {
        status_t              status;
        logic                 found;
        logic [OUT_IDX_W-1:0] position;
        logic [OUT_IDX_W-1:0] entry_count;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    scs_in_if  in_ch ();
    scs_out_if out_ch ();

    sorted_coordinate_set_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Request beats still to be offered, and the results they are due to
    // produce, oldest first.
    request_t    pending_requests[$];
    outcome_t    expected_outcomes[$];
    int unsigned total_requests = 0;
    int unsigned requests_taken = 0;
    int unsigned results_taken  = 0;
    int unsigned mismatches     = 0;
    int unsigned status_tally[5];

    // Behavioural copy of the set. Entries at or above held_keys are never
    // read, exactly as in the block, so their reset value does not matter.
    logic [KEY_W-1:0] shadow_keys[CAPACITY];
    int unsigned      held_keys = 0;

    // Binary search over the held keys. Returns the index of the key when
    // it is present, otherwise the index at which it would be inserted.
    function automatic int unsigned locate_key(input logic [KEY_W-1:0] key,
                                               output logic hit);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo  = 0;
        hi  = held_keys;
        hit = 1'b0;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (key == shadow_keys[mid])
            begin
                hit = 1'b1;
                return mid;
            end
            if (key < shadow_keys[mid])
                hi = mid;
            else
                lo = mid + 1;
        end
        return lo;
    endfunction

    // Applies one accepted request to the shadow set and returns the result
    // that the block must report for it.
    function automatic outcome_t apply_request(input request_t req);
        outcome_t         res;
        logic [KEY_W-1:0] key;
        logic             hit;
        int unsigned      slot;
        key  = {req.key_y, req.key_x};
        hit  = 1'b0;
        slot = 0;
        if (req.action == ACT_CLEAR)
        begin
            held_keys  = 0;
            res.status = ST_CLEARED;
        end
        else
        begin
            slot = locate_key(key, hit);
            if (req.action != ACT_INSERT)
                res.status = ST_LOOKUP;
            else if (hit)
                res.status = ST_DUPLICATE;
            else if (held_keys >= CAPACITY)
                res.status = ST_FULL;
            else
            begin
                // Open a gap at the insertion point by moving the upper
                // entries up one place.
                for (int unsigned i = held_keys; i > slot; i--)
                    shadow_keys[i] = shadow_keys[i - 1];
                shadow_keys[slot] = key;
                held_keys++;
                res.status = ST_INSERTED;
            end
        end
        res.found       = hit;
        res.position    = slot[OUT_IDX_W-1:0];
        res.entry_count = held_keys[OUT_IDX_W-1:0];
        status_tally[res.status]++;
        return res;
    endfunction

    // Three stall phases follow the progress of each channel: first the
    // sender idles lightly and the receiver heavily, then the other way
    // round, and in the last third neither side idles at all.
    function automatic int unsigned idle_share(input int unsigned done,
                                               input bit sender);
        int unsigned phase;
        phase = (total_requests == 0) ? 0 : (done * 3) / total_requests;
        case (phase)
            0:       return sender ? 15 : 50;
            1:       return sender ? 50 : 15;
            default: return 0;
        endcase
    endfunction

    // Request driver. A beat is held until it is taken. Once the slot is
    // free, the next beat is either offered or a gap is left at random.
    // The predictor is stepped on the edge at which a beat is accepted.
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        request_t next_req;
        if (!rst_n)
        begin
            in_ch.valid  <= 1'b0;
            in_ch.action <= ACT_CLEAR;
            in_ch.key_x  <= '0;
            in_ch.key_y  <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                expected_outcomes.push_back(
                    apply_request({in_ch.action, in_ch.key_x, in_ch.key_y}));
                requests_taken++;
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_requests.size() != 0 &&
                    $urandom_range(99) >= idle_share(requests_taken, 1'b1))
                begin
                    next_req     = pending_requests.pop_front();
                    in_ch.valid  <= 1'b1;
                    in_ch.action <= next_req.action;
                    in_ch.key_x  <= next_req.key_x;
                    in_ch.key_y  <= next_req.key_y;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor. Every accepted result beat must match the oldest
    // expectation in each field. Ready is redrawn on every edge.
    always @(posedge clk or negedge rst_n)
    begin : check_results
        outcome_t want;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_taken++;
                if (expected_outcomes.size() == 0)
                begin
                    $error("result beat arrived with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (out_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d",
                               want.status, out_ch.status);
                        mismatches++;
                    end
                    if (out_ch.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d",
                               want.found, out_ch.found);
                        mismatches++;
                    end
                    if (out_ch.position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, out_ch.position);
                        mismatches++;
                    end
                    if (out_ch.entry_count !== want.entry_count)
                    begin
                        $error("entry_count: expected %0d, actual %0d",
                               want.entry_count, out_ch.entry_count);
                        mismatches++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= idle_share(results_taken, 1'b0));
        end
    end

    // Watchdog: a long run of cycles in which neither channel moves a beat
    // means the block has hung. The limit leaves a wide margin over the worst
    // insert with a full shift.
    always @(posedge clk)
    begin : watch_progress
        int unsigned quiet_cycles;
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_request(input action_t action, input logic [7:0] x,
                                 input logic [7:0] y);
        pending_requests.push_back({action, x, y});
    endtask

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(255));
    endfunction

    initial
    begin : run_test
        logic [KEY_W-1:0] issued[$];
        logic [KEY_W-1:0] pick;
        int unsigned      random_count;
        int unsigned      fill_len;
        int unsigned      seg_len;
        int unsigned      roll;
        bit               first_segment;

        in_ch.valid  = 1'b0;
        in_ch.action = ACT_CLEAR;
        in_ch.key_x  = '0;
        in_ch.key_y  = '0;
        out_ch.ready = 1'b0;
        rst_n        = 1'b0;

        // Directed part: empty set, keys at both extremes of both fields,
        // insertion at the front and at the back, a duplicate, the spare
        // action code, and a clear followed by reuse of the emptied set.
        queue_request(ACT_LOOKUP, 8'h00, 8'h00);
        queue_request(ACT_INSERT, 8'hFF, 8'hFF);
        queue_request(ACT_INSERT, 8'h00, 8'h00);
        queue_request(ACT_INSERT, 8'h00, 8'h00);
        queue_request(ACT_INSERT, 8'hFF, 8'h00);
        queue_request(ACT_INSERT, 8'h00, 8'hFF);
        queue_request(ACT_INSERT, 8'h80, 8'h7F);
        queue_request(ACT_INSERT, 8'h7F, 8'h80);
        queue_request(ACT_LOOKUP, 8'hFF, 8'hFF);
        queue_request(ACT_LOOKUP, 8'h00, 8'h00);
        queue_request(ACT_LOOKUP, 8'h80, 8'h80);
        queue_request(ACT_SPARE,  8'h00, 8'hFF);
        queue_request(ACT_SPARE,  8'h55, 8'hAA);
        queue_request(ACT_INSERT, 8'hFF, 8'hFF);
        queue_request(ACT_CLEAR,  8'hFF, 8'hFF);
        queue_request(ACT_LOOKUP, 8'hFF, 8'hFF);
        queue_request(ACT_INSERT, 8'hAA, 8'h55);
        queue_request(ACT_INSERT, 8'h55, 8'h55);
        queue_request(ACT_LOOKUP, 8'hAA, 8'h55);
        queue_request(ACT_CLEAR,  8'h00, 8'h00);

        // Random part, built from segments that each start from an empty
        // set. Fill segments drive the table to capacity and then hammer it
        // with full and duplicate rejections. Pool segments use a narrow
        // key range so that duplicates and found lookups are common. Noise
        // segments mix every action code with keys over the whole range.
        random_count  = 0;
        first_segment = 1'b1;
        while (random_count < RANDOM_ITEMS)
        begin
            issued.delete();
            queue_request(ACT_CLEAR, any_byte(), any_byte());
            random_count++;
            roll = first_segment ? 0 : $urandom_range(2);
            first_segment = 1'b0;
            if (roll == 0)
            begin
                fill_len = CAPACITY + $urandom_range(12);
                for (int unsigned i = 0; i < fill_len; i++)
                begin
                    pick = {any_byte(), any_byte()};
                    issued.push_back(pick);
                    queue_request(ACT_INSERT, pick[7:0], pick[15:8]);
                end
                for (int unsigned i = 0; i < 12; i++)
                begin
                    pick = ($urandom_range(1) == 0) ?
                           issued[$urandom_range(issued.size() - 1)] :
                           {any_byte(), any_byte()};
                    case ($urandom_range(3))
                        0, 1:    queue_request(ACT_INSERT, pick[7:0], pick[15:8]);
                        2:       queue_request(ACT_LOOKUP, pick[7:0], pick[15:8]);
                        default: queue_request(ACT_SPARE,  pick[7:0], pick[15:8]);
                    endcase
                end
                random_count += fill_len + 12;
            end
            else if (roll == 1)
            begin
                seg_len = 30 + $urandom_range(30);
                for (int unsigned i = 0; i < seg_len; i++)
                begin
                    pick = {8'($urandom_range(3)), 8'($urandom_range(7))};
                    if ($urandom_range(2) == 0)
                        queue_request(ACT_LOOKUP, pick[7:0], pick[15:8]);
                    else
                        queue_request(ACT_INSERT, pick[7:0], pick[15:8]);
                end
                random_count += seg_len;
            end
            else
            begin
                seg_len = 20 + $urandom_range(30);
                for (int unsigned i = 0; i < seg_len; i++)
                begin
                    if (issued.size() != 0 && $urandom_range(2) == 0)
                        pick = issued[$urandom_range(issued.size() - 1)];
                    else
                        pick = {any_byte(), any_byte()};
                    roll = $urandom_range(19);
                    if (roll == 0)
                    begin
                        issued.delete();
                        queue_request(ACT_CLEAR, pick[7:0], pick[15:8]);
                    end
                    else if (roll < 11)
                    begin
                        issued.push_back(pick);
                        queue_request(ACT_INSERT, pick[7:0], pick[15:8]);
                    end
                    else if (roll < 17)
                        queue_request(ACT_LOOKUP, pick[7:0], pick[15:8]);
                    else
                        queue_request(ACT_SPARE, pick[7:0], pick[15:8]);
                end
                random_count += seg_len;
            end
        end
        total_requests = pending_requests.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request has been taken and answered, then let
        // the block run on for a while so that any stray beat is caught.
        while (pending_requests.size() != 0 || in_ch.valid ||
               expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d request beats: %0d clears, %0d inserts, %0d duplicates,",
                 requests_taken, status_tally[ST_CLEARED], status_tally[ST_INSERTED],
                 status_tally[ST_DUPLICATE]);
        $display("%0d rejected as full and %0d lookups; %0d field mismatches.",
                 status_tally[ST_FULL], status_tally[ST_LOOKUP], mismatches);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
